[rtl/hkvt_pkg.sv]
// Shared types and constants of the hashed key-value table.
package hkvt_pkg;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [63:0] HASH_MULT  = 64'hff51afd7ed558ccd;
  localparam int          HASH_SHIFT = 33;

  localparam int         CFG_BITS  = 9;
  localparam logic [8:0] CFG_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        found;
    logic [63:0] value_out;
  } rsp_t;

endpackage

[rtl/hkvt_fifo.sv]
// Two-entry queue used between the front and back and on the result side.
module hkvt_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic [1:0]   count;
  logic         wp;
  logic         rp;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= din;
  end

endmodule

[rtl/hkvt_front.sv]
// Front end: takes requests, hashes the key and reduces it to a bucket index.
module hkvt_front #(
  parameter int BUCKETS = 256,
  parameter int BW      = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  hkvt_pkg::req_t req,
  input  logic [8:0]     num_buckets,
  output logic           out_valid,
  input  logic           out_ready,
  output hkvt_pkg::req_t out_req,
  output logic [BW-1:0]  out_bucket
);
  import hkvt_pkg::*;

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_MUL0 = 7'b0000010,
    F_MUL1 = 7'b0000100,
    F_MUL2 = 7'b0001000,
    F_FOLD = 7'b0010000,
    F_MOD  = 7'b0100000,
    F_DONE = 7'b1000000
  } fstate_t;

  fstate_t     state;
  req_t        cur;
  logic [63:0] x;
  logic [63:0] p0;
  logic [31:0] hi;
  logic [8:0]  rem;
  logic [2:0]  cnt;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] hsum;
  logic [8:0]  eff_n;
  logic [8:0]  rem_next;

  assign full       = (state != F_IDLE);
  assign out_valid  = (state == F_DONE);
  assign out_req    = cur;
  assign out_bucket = BW'(rem);

  always_comb begin
    if (num_buckets == 9'd0) eff_n = 9'd1;
    else if (32'(num_buckets) > BUCKETS) eff_n = 9'(BUCKETS);
    else eff_n = num_buckets;
  end

  // one shared 32x32 multiplier, low 64 bits of x * HASH_MULT over three steps
  always_comb begin
    mul_a = x[31:0];
    mul_b = HASH_MULT[31:0];
    case (state)
      F_MUL1:  mul_b = HASH_MULT[63:32];
      F_MUL2:  mul_a = x[63:32];
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign hsum  = p0 + {hi, 32'd0};

  // one byte of the hash per cycle into the running remainder
  always_comb begin
    logic [9:0] t;
    t = {1'b0, rem};
    for (int i = 0; i < 8; i++) begin
      t = {t[8:0], x[63-i]};
      if (t >= {1'b0, eff_n}) t = t - {1'b0, eff_n};
    end
    rem_next = t[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= 3'd0;
    end else begin
      case (state)
        F_IDLE:  if (push) state <= F_MUL0;
        F_MUL0:  state <= F_MUL1;
        F_MUL1:  state <= F_MUL2;
        F_MUL2:  state <= F_FOLD;
        F_FOLD: begin
          state <= F_MOD;
          cnt   <= 3'd0;
        end
        F_MOD: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) state <= F_DONE;
        end
        F_DONE:  if (out_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (push) begin
          cur <= req;
          x   <= req.key ^ (req.key >> HASH_SHIFT);
        end
      end
      F_MUL0: p0 <= mul_p;
      F_MUL1: hi <= mul_p[31:0];
      F_MUL2: hi <= hi + mul_p[31:0];
      F_FOLD: begin
        x   <= hsum ^ (hsum >> HASH_SHIFT);
        rem <= 9'd0;
      end
      F_MOD: begin
        x   <= {x[55:0], 8'd0};
        rem <= rem_next;
      end
      default: ;
    endcase
  end

endmodule

[rtl/hkvt_back.sv]
// Back end: bucket read, way compare and row write-back against the tables.
module hkvt_back #(
  parameter int BUCKETS    = 256,
  parameter int WAYS       = 4,
  parameter int VALUE_BITS = 64,
  parameter int BW         = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_pop,
  input  hkvt_pkg::req_t in_req,
  input  logic [BW-1:0]  in_bucket,
  input  logic           rsp_full,
  output logic           rsp_push,
  output hkvt_pkg::rsp_t rsp
);
  import hkvt_pkg::*;

  localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_READ  = 3'b010,
    B_EXEC  = 3'b100
  } bstate_t;

  bstate_t state;
  logic [BW-1:0] clr_addr;
  req_t          cur;
  logic [BW-1:0] cur_bkt;

  logic [WAYS-1:0]                 vld_mem [BUCKETS];
  logic [WAYS-1:0][63:0]           key_mem [BUCKETS];
  logic [WAYS-1:0][VALUE_BITS-1:0] val_mem [BUCKETS];

  logic [WAYS-1:0]                 rd_vld;
  logic [WAYS-1:0][63:0]           rd_key;
  logic [WAYS-1:0][VALUE_BITS-1:0] rd_val;

  logic [WAYS-1:0]                 nv;
  logic [WAYS-1:0][63:0]           nk;
  logic [WAYS-1:0][VALUE_BITS-1:0] nval;
  logic [WAYS-1:0]                 hit;
  logic [WI-1:0]                   hit_idx;
  logic [WI-1:0]                   free_idx;
  logic                            any_hit;
  logic                            any_free;
  logic [VALUE_BITS-1:0]           v;
  logic                            status;
  logic                            found;
  logic [63:0]                     vout;

  logic            vld_we;
  logic [BW-1:0]   vld_addr;
  logic [WAYS-1:0] vld_wdata;
  logic            exec;

  assign exec     = (state == B_EXEC);
  assign in_pop   = (state == B_READ) && in_valid && !rsp_full;
  assign rsp_push = exec;
  assign rsp      = '{status: status, found: found, value_out: vout};
  assign v        = cur.value[VALUE_BITS-1:0];

  always_comb begin
    for (int w = 0; w < WAYS; w++) hit[w] = rd_vld[w] && (rd_key[w] == cur.key);
    any_hit  = |hit;
    any_free = ~&rd_vld;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) hit_idx = WI'(w);
      if (!rd_vld[w]) free_idx = WI'(w);
    end
  end

  always_comb begin
    nv     = rd_vld;
    nk     = rd_key;
    nval   = rd_val;
    status = 1'b0;
    found  = 1'b0;
    vout   = 64'd0;
    case (cur.cmd)
      CMD_PUT: begin
        if (any_hit) begin
          nval[hit_idx] = v;
        end else if (any_free) begin
          nv[free_idx]   = 1'b1;
          nk[free_idx]   = cur.key;
          nval[free_idx] = v;
        end else begin
          status = 1'b1;
        end
      end
      CMD_GET: begin
        if (any_hit) begin
          found = 1'b1;
          vout  = 64'(rd_val[hit_idx]);
        end
      end
      CMD_REMOVE: if (any_hit) nv[hit_idx] = 1'b0;
      default: ;
    endcase
  end

  assign vld_we    = (state == B_CLEAR) || exec;
  assign vld_addr  = (state == B_CLEAR) ? clr_addr : cur_bkt;
  assign vld_wdata = (state == B_CLEAR) ? '0 : nv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BW'(BUCKETS - 1)) state <= B_READ;
        end
        B_READ:  if (in_pop) state <= B_EXEC;
        B_EXEC:  state <= B_READ;
        default: state <= B_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      cur     <= in_req;
      cur_bkt <= in_bucket;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_we) vld_mem[vld_addr] <= vld_wdata;
    if (in_pop) rd_vld <= vld_mem[in_bucket];
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      key_mem[cur_bkt] <= nk;
      val_mem[cur_bkt] <= nval;
    end
    if (in_pop) begin
      rd_key <= key_mem[in_bucket];
      rd_val <= val_mem[in_bucket];
    end
  end

  a_read_then_result: assert property (@(posedge clk) disable iff (rst)
    in_pop |=> rsp_push)
    else $error("bucket read not followed by a result");

  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    rsp_push |-> !rsp_full)
    else $error("result pushed into a full queue");

  a_full_only_on_put: assert property (@(posedge clk) disable iff (rst)
    (rsp_push && rsp.status) |-> ((&rd_vld) && (cur.cmd == CMD_PUT)))
    else $error("table full flagged with a free way or on a non-put");

  a_found_only_on_get: assert property (@(posedge clk) disable iff (rst)
    (rsp_push && rsp.found) |-> ((|rd_vld) && (cur.cmd == CMD_GET)))
    else $error("found flagged without a valid way or on a non-get");

endmodule

[rtl/hashed_key_value_table_unit.sv]
// Top level of the hashed key-value table: config register, front, queues, back.
// Requests (put, get, remove) enter through push/full and results leave in order
// through empty/pop. The front takes one request at a time: three steps of one shared
// 32x32 multiplier for the hash, one fold, byte-wise modulo of the hash by the bucket
// count, and a handoff; this sets the sustained rate. The back handles a request as
// a registered bucket read, then compare and row write-back, and a two-entry queue on
// each side lets front, back and result taker stall independently. After reset the
// valid table is cleared one bucket per cycle over all BUCKETS buckets, during which
// requests are queued but not executed; num_buckets writes are taken at any time and
// should be made while no request is in flight.
module hashed_key_value_table_unit #(
  parameter int BUCKETS    = 256,
  parameter int WAYS       = 4,
  parameter int VALUE_BITS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  hkvt_pkg::req_t req,
  output logic           empty,
  input  logic           pop,
  output hkvt_pkg::rsp_t rsp,
  input  logic           cfg_write,
  input  logic [8:0]     cfg_data
);
  import hkvt_pkg::*;

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int MID_W = $bits(req_t) + BW;
  localparam int RSP_W = $bits(rsp_t);

  logic [CFG_BITS-1:0] num_buckets;

  logic             f_valid;
  req_t             f_req;
  logic [BW-1:0]    f_bucket;
  logic             mid_full;
  logic             mid_empty;
  logic [MID_W-1:0] mid_dout;
  logic             b_pop;
  req_t             b_req;
  logic [BW-1:0]    b_bucket;
  logic             rsp_full;
  logic             rsp_push;
  rsp_t             b_rsp;
  logic [RSP_W-1:0] rsp_dout;

  always_ff @(posedge clk) begin
    if (rst) num_buckets <= CFG_RESET;
    else if (cfg_write) num_buckets <= cfg_data;
  end

  hkvt_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req        (req),
    .num_buckets(num_buckets),
    .out_valid  (f_valid),
    .out_ready  (!mid_full),
    .out_req    (f_req),
    .out_bucket (f_bucket)
  );

  hkvt_fifo #(.W(MID_W)) u_mid (
    .clk  (clk),
    .rst  (rst),
    .push (f_valid),
    .din  ({f_req, f_bucket}),
    .full (mid_full),
    .pop  (b_pop),
    .dout (mid_dout),
    .empty(mid_empty)
  );

  assign b_req    = mid_dout[MID_W-1:BW];
  assign b_bucket = mid_dout[BW-1:0];

  hkvt_back #(
    .BUCKETS   (BUCKETS),
    .WAYS      (WAYS),
    .VALUE_BITS(VALUE_BITS),
    .BW        (BW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!mid_empty),
    .in_pop   (b_pop),
    .in_req   (b_req),
    .in_bucket(b_bucket),
    .rsp_full (rsp_full),
    .rsp_push (rsp_push),
    .rsp      (b_rsp)
  );

  hkvt_fifo #(.W(RSP_W)) u_rsp (
    .clk  (clk),
    .rst  (rst),
    .push (rsp_push),
    .din  (b_rsp),
    .full (rsp_full),
    .pop  (pop),
    .dout (rsp_dout),
    .empty(empty)
  );

  assign rsp = rsp_dout;

endmodule

[bench/hashed_key_value_table_unit_tb.sv]
// Testbench of the hashed key-value table: queue-fed driver, checking monitor.
`timescale 1ns / 100ps

module hashed_key_value_table_unit_tb;
  import hkvt_pkg::*;

  localparam int BUCKETS = 256;
  localparam int WAYS = 4;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;
  logic cfg_write = 1'b0;
  logic [8:0] cfg_data = '0;

  hashed_key_value_table_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp), .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit          tbl_valid[SLOTS];
  logic [63:0] tbl_key[SLOTS];
  logic [63:0] tbl_value[SLOTS];
  logic [8:0]  buckets_in_use = CFG_RESET;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   hold_push = 1'b0;
  int   push_gap = 0;
  int   pop_gap = 0;
  logic [63:0] used_keys[$];

  // full and empty as seen at the last rising edge
  logic full_at_edge = 1'b1;
  logic empty_at_edge = 1'b1;

  function automatic int bucket_index(logic [63:0] k);
    logic [63:0] h;
    int n;
    n = buckets_in_use;
    if (n == 0) n = 1;
    if (n > BUCKETS) n = BUCKETS;
    h = k ^ (k >> HASH_SHIFT);
    h = h * HASH_MULT;
    h = h ^ (h >> HASH_SHIFT);
    return int'(h % 64'(n));
  endfunction

  function automatic rsp_t table_access(req_t r);
    rsp_t o;
    int base, hit;
    bit placed;
    o = '0;
    base = bucket_index(r.key) * WAYS;
    hit = -1;
    placed = 1'b0;
    for (int w = 0; w < WAYS; w++)
      if (hit < 0 && tbl_valid[base + w] && tbl_key[base + w] == r.key) hit = base + w;
    case (r.cmd)
      CMD_PUT: begin
        if (hit >= 0) tbl_value[hit] = r.value;
        else begin
          for (int w = 0; w < WAYS; w++)
            if (!placed && !tbl_valid[base + w]) begin
              tbl_valid[base + w] = 1'b1;
              tbl_key[base + w] = r.key;
              tbl_value[base + w] = r.value;
              placed = 1'b1;
            end
          if (!placed) o.status = 1'b1;
        end
      end
      CMD_GET: begin
        if (hit >= 0) begin
          o.found = 1'b1;
          o.value_out = tbl_value[hit];
        end
      end
      CMD_REMOVE: if (hit >= 0) tbl_valid[hit] = 1'b0;
      default: ;
    endcase
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (push && !full_at_edge) begin
        expected_rsps.push_back(table_access(req));
        void'(pending_reqs.pop_front());
      end
      // a request that was refused stays on the ports unchanged
      if (!push || !full_at_edge) begin
        if (push_gap > 0) begin
          push_gap <= push_gap - 1;
          push <= 1'b0;
        end else if (!hold_push && pending_reqs.size() > 0) begin
          push <= 1'b1;
          req <= pending_reqs[0];
          push_gap <= gap_len();
        end else push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    full_at_edge <= full;
    empty_at_edge <= empty;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp);
          errors <= errors + 1;
        end else if (rsp !== expected_rsps[0]) begin
          $display("%0t: result mismatch expected %p actual %p", $time,
                   expected_rsps[0], rsp);
          errors <= errors + 1;
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (pop && !empty_at_edge && expected_rsps.size() > 0) void'(expected_rsps.pop_front());
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (pop && !empty_at_edge) pop_gap <= gap_len();
      end
    end
  end

  task automatic add_req(logic [1:0] c, logic [63:0] k, logic [63:0] v);
    req_t r;
    r.cmd = c;
    r.key = k;
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || push) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_buckets(logic [8:0] n);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= n;
    @(negedge clk);
    cfg_write <= 1'b0;
    buckets_in_use = n;
  endtask

  task automatic random_phase(int count);
    logic [63:0] k;
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(99);
      if (used_keys.size() == 0 || p < 30) begin
        k = rand64();
        if ($urandom_range(3) == 0) k = {48'd0, 16'($urandom_range(40))};
        used_keys.push_back(k);
      end else k = used_keys[$urandom_range(used_keys.size() - 1)];
      p = $urandom_range(99);
      if (p < 40) add_req(CMD_PUT, k, rand64());
      else if (p < 75) add_req(CMD_GET, k, rand64());
      else if (p < 97) add_req(CMD_REMOVE, k, rand64());
      else add_req(CMD_NONE, k, rand64());
      if (used_keys.size() > 200) used_keys.delete(0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, all commands, full bucket, update, absent remove
    set_buckets(9'd1);
    add_req(CMD_GET, 64'd0, '1);
    add_req(CMD_PUT, 64'd0, '1);
    add_req(CMD_PUT, '1, 64'd0);
    add_req(CMD_PUT, 64'd5, 64'h0123456789abcdef);
    add_req(CMD_PUT, 64'd6, 64'hfedcba9876543210);
    add_req(CMD_PUT, 64'd7, 64'd1);
    add_req(CMD_PUT, 64'd5, 64'haaaaaaaa55555555);
    add_req(CMD_GET, 64'd5, 64'd0);
    add_req(CMD_GET, '1, 64'd0);
    add_req(CMD_REMOVE, 64'd99, 64'd0);
    add_req(CMD_REMOVE, 64'd6, 64'd0);
    add_req(CMD_PUT, 64'd7, 64'd2);
    add_req(CMD_GET, 64'd6, 64'd0);
    add_req(CMD_NONE, 64'd5, '1);
    add_req(CMD_GET, 64'd0, 64'd0);
    // sender pauses midway until every result so far has come back
    while (pending_reqs.size() > 8) @(negedge clk);
    hold_push = 1'b1;
    while (expected_rsps.size() > 0 || push) @(negedge clk);
    repeat (20) @(negedge clk);
    hold_push = 1'b0;
    drain();
    set_buckets(9'd0);
    random_phase(100);
    set_buckets(9'd256);
    random_phase(150);
    set_buckets(9'd511);
    random_phase(100);
    set_buckets(9'd3);
    random_phase(150);
    set_buckets(9'd97);
    random_phase(100);
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[files.f]
rtl/hkvt_pkg.sv
rtl/hkvt_fifo.sv
rtl/hkvt_front.sv
rtl/hkvt_back.sv
rtl/hashed_key_value_table_unit.sv
bench/hashed_key_value_table_unit_tb.sv
